/* src/fhlc_pkg.sv */
package fhlc_pkg;

  localparam int XW   = 10;
  localparam int YW   = 16;
  localparam int DW   = 17;
  localparam int ERRW = 18;

  // Request operation codes.
  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_DRAW  = 1'b1;

  typedef logic        [XW-1:0] col_t;
  typedef logic signed [YW-1:0] hgt_t;

  localparam hgt_t EMPTY_LOW  = 16'sd32000;
  localparam hgt_t EMPTY_HIGH = -16'sd32000;

  // One horizon column: lowest and highest height plotted so far.
  typedef struct packed {
    hgt_t low;
    hgt_t high;
  } hzn_t;

  // One visible run as kept in the run buffer.
  typedef struct packed {
    col_t x_from;
    hgt_t y_from;
    col_t x_to;
    hgt_t y_to;
  } run_t;

  // Start values for the line stepper, already ordered along the major axis.
  typedef struct packed {
    logic             steep;
    logic             neg;
    col_t             x;
    hgt_t             y;
    col_t             x_end;
    hgt_t             y_end;
    logic [DW-1:0]    dmaj;
    logic [DW-1:0]    dmin;
  } step_init_t;

  // Current pixel of the stepper.
  typedef struct packed {
    col_t x;
    hgt_t y;
    logic done;
  } step_pos_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_ORDER,
    ST_COL_RD,
    ST_PT_EV,
    ST_VT_EV,
    ST_VT_RUN2,
    ST_W_RD,
    ST_W_EV,
    ST_W_END,
    ST_E_RD,
    ST_E_LD,
    ST_E_WAIT
  } fsm_e;

endpackage

/* src/fhlc_if.sv */
// Request channel carrying one clear or draw command.
interface fhlc_in_if;
  logic                  valid;
  logic                  ready;
  logic                  op;
  fhlc_pkg::col_t        x_start;
  fhlc_pkg::hgt_t        y_start;
  fhlc_pkg::col_t        x_end;
  fhlc_pkg::hgt_t        y_end;

  modport source (output valid, op, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, op, x_start, y_start, x_end, y_end, output ready);
endinterface

// Result channel carrying one visible run per transfer.
interface fhlc_out_if;
  logic                  valid;
  logic                  ready;
  fhlc_pkg::col_t        seg_x_from;
  fhlc_pkg::hgt_t        seg_y_from;
  fhlc_pkg::col_t        seg_x_to;
  fhlc_pkg::hgt_t        seg_y_to;
  logic                  last;
  logic                  overflow;

  modport source (output valid, seg_x_from, seg_y_from, seg_x_to, seg_y_to, last, overflow,
                  input ready);
  modport sink   (input valid, seg_x_from, seg_y_from, seg_x_to, seg_y_to, last, overflow,
                  output ready);
endinterface

/* src/floating_horizon_line_clipper.sv */
// Floating-horizon hidden-line clipper. A draw request steps its segment one pixel at a time
// through a horizon memory with one write port and one read port (per pixel a read, then a
// test and write back); a single point or vertical segment whose column lies in the horizon
// is instead tested against that column with one read. The visible runs are buffered and then
// sent out one by one, each held until the output is ready, with overflow valid on every run
// of the line. A clear request, and reset itself, sweeps the horizon memory at one column per
// cycle, and no request is taken during the sweep. The block takes one request at a time and
// is ready again only after the last run of the previous line has been sent.
module floating_horizon_line_clipper #(
  parameter int HORIZON_WIDTH = 1024,
  parameter int MAX_RUNS      = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fhlc_in_if.sink    in_i,
  fhlc_out_if.source out_o
);
  import fhlc_pkg::*;

  localparam int CW  = $clog2(HORIZON_WIDTH);
  localparam int XCW = ((CW > XW) ? CW : XW) + 1;
  localparam int RAW = $clog2(MAX_RUNS);
  localparam int RCW = $clog2(MAX_RUNS + 1);
  localparam int RUNW = $bits(run_t);
  localparam int HZW  = $bits(hzn_t);

  fsm_e              state_q, state_d;
  col_t              xa_q, xb_q;
  hgt_t              ya_q, yb_q;
  logic [DW-1:0]     dx_q, dy_q;
  logic [CW-1:0]     clr_q;
  logic              first_q, vis_q, start_here_q;
  col_t              px_q, sx_q;
  hgt_t              py_q, sy_q;
  hgt_t              r2_q;
  logic [RCW-1:0]    run_cnt_q, emit_q;
  logic              dropped_q;
  run_t              run_q;
  logic              last_q, ovf_q;

  // Horizon memory and run buffer ports.
  logic              hz_we;
  logic [CW-1:0]     hz_waddr, hz_raddr;
  hzn_t              hz_wdata, hz_rd;
  logic [HZW-1:0]    hz_rdata;
  logic              add_req;
  run_t              add_run;
  logic              rb_we;
  logic [RUNW-1:0]   rb_rdata;

  // Stepper control.
  logic              step_load, step_en;
  step_init_t        step_init;
  step_pos_t         pos;

  // Setup and walk helpers.
  logic signed [XW:0] dxs;
  logic signed [YW:0] dys;
  logic [DW-1:0]      dx_abs, dy_abs;
  logic               shallow, swap, col_ok_a, col_ok_p, hit;
  logic               vt_two;
  hgt_t               vt_r2;

  assign hz_rd = hzn_t'(hz_rdata);

  fhlc_ram #(.WIDTH(HZW), .DEPTH(HORIZON_WIDTH)) u_hzn_ram (
    .clk_i   (clk_i),
    .we_i    (hz_we),
    .waddr_i (hz_waddr),
    .wdata_i (hz_wdata),
    .raddr_i (hz_raddr),
    .rdata_o (hz_rdata)
  );

  fhlc_ram #(.WIDTH(RUNW), .DEPTH(MAX_RUNS)) u_run_ram (
    .clk_i   (clk_i),
    .we_i    (rb_we),
    .waddr_i (run_cnt_q[RAW-1:0]),
    .wdata_i (add_run),
    .raddr_i (emit_q[RAW-1:0]),
    .rdata_o (rb_rdata)
  );

  fhlc_stepper u_stepper (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (step_load),
    .init_i (step_init),
    .step_i (step_en),
    .pos_o  (pos)
  );

  // Endpoint distances and line classification.
  always_comb begin
    dxs      = $signed({1'b0, xb_q}) - $signed({1'b0, xa_q});
    dys      = $signed({yb_q[YW-1], yb_q}) - $signed({ya_q[YW-1], ya_q});
    dx_abs   = DW'($unsigned(dxs[XW] ? -dxs : dxs));
    dy_abs   = DW'($unsigned(dys[YW] ? -dys : dys));
    shallow  = dx_q >= dy_q;
    swap     = shallow ? (xb_q < xa_q) : (yb_q < ya_q);
    col_ok_a = XCW'(xa_q) < XCW'(HORIZON_WIDTH);
    col_ok_p = XCW'(pos.x) < XCW'(HORIZON_WIDTH);
    hit      = col_ok_p && ((pos.y <= hz_rd.low) || (pos.y >= hz_rd.high));

    step_init.steep = !shallow;
    step_init.x     = swap ? xb_q : xa_q;
    step_init.y     = swap ? yb_q : ya_q;
    step_init.x_end = swap ? xa_q : xb_q;
    step_init.y_end = swap ? ya_q : yb_q;
    step_init.neg   = shallow ? (step_init.y_end < step_init.y)
                              : (step_init.x_end < step_init.x);
    step_init.dmaj  = shallow ? dx_q : dy_q;
    step_init.dmin  = shallow ? dy_q : dx_q;
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state, memory writes and run capture.
  always_comb begin
    state_d   = state_q;
    hz_we     = 1'b0;
    hz_waddr  = CW'(xa_q);
    hz_wdata  = hz_rd;
    hz_raddr  = (state_q == ST_W_RD) ? CW'(pos.x) : CW'(xa_q);
    add_req   = 1'b0;
    add_run   = '{x_from: xa_q, y_from: ya_q, x_to: xa_q, y_to: yb_q};
    step_load = 1'b0;
    step_en   = 1'b0;
    vt_two    = 1'b0;
    vt_r2     = hz_rd.low;
    unique case (state_q)
      ST_CLEAR: begin
        hz_we    = 1'b1;
        hz_waddr = clr_q;
        hz_wdata = '{low: EMPTY_LOW, high: EMPTY_HIGH};
        if (clr_q == CW'(HORIZON_WIDTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = (in_i.op == OP_DRAW) ? ST_SETUP : ST_CLEAR;
        end
      end
      ST_SETUP: begin
        state_d = ST_ORDER;
      end
      ST_ORDER: begin
        if (xa_q == xb_q) begin
          state_d = col_ok_a ? ST_COL_RD : ST_E_RD;
        end else begin
          step_load = 1'b1;
          state_d   = ST_W_RD;
        end
      end
      ST_COL_RD: begin
        state_d = (ya_q == yb_q) ? ST_PT_EV : ST_VT_EV;
      end
      ST_PT_EV: begin
        // Single point: strictly outside the horizon to be visible.
        add_run = '{x_from: xa_q, y_from: ya_q, x_to: xa_q, y_to: ya_q};
        if (ya_q < hz_rd.low) begin
          hz_we        = 1'b1;
          hz_wdata.low = ya_q;
          add_req      = 1'b1;
        end else if (ya_q > hz_rd.high) begin
          hz_we         = 1'b1;
          hz_wdata.high = ya_q;
          add_req       = 1'b1;
        end
        state_d = ST_E_RD;
      end
      ST_VT_EV: begin
        // Vertical segment, heights ordered so that ya is the lower end.
        hz_we = 1'b1;
        if (ya_q >= hz_rd.high) begin
          add_req       = 1'b1;
          hz_wdata.high = yb_q;
          if (ya_q <= hz_rd.low) begin
            hz_wdata.low = ya_q;
          end
        end else if (ya_q <= hz_rd.low) begin
          hz_wdata.low = ya_q;
          add_req      = 1'b1;
          if (yb_q < hz_rd.low) begin
            if (yb_q > hz_rd.high) begin
              hz_wdata.high = yb_q;
            end
          end else if (yb_q <= hz_rd.high) begin
            add_run.y_to = hz_rd.low;
            if (hz_rd.low > hz_rd.high) begin
              hz_wdata.high = hz_rd.low;
            end
          end else begin
            // Upper part first, lower part follows in the next cycle.
            add_run.y_from = hz_rd.high;
            vt_two         = 1'b1;
            hz_wdata.high  = (hz_rd.low > yb_q) ? hz_rd.low : yb_q;
          end
        end else if (yb_q > hz_rd.high) begin
          add_req        = 1'b1;
          add_run.y_from = hz_rd.high;
          hz_wdata.high  = yb_q;
          if (hz_rd.high <= hz_rd.low) begin
            hz_wdata.low = hz_rd.high;
          end
        end
        state_d = vt_two ? ST_VT_RUN2 : ST_E_RD;
      end
      ST_VT_RUN2: begin
        add_req      = 1'b1;
        add_run.y_to = r2_q;
        state_d      = ST_E_RD;
      end
      ST_W_RD: begin
        state_d = ST_W_EV;
      end
      ST_W_EV: begin
        hz_waddr = CW'(pos.x);
        add_run  = '{x_from: sx_q, y_from: sy_q, x_to: px_q, y_to: py_q};
        if (!first_q) begin
          hz_we = col_ok_p;
          if (pos.y <= hz_rd.low) begin
            hz_wdata.low = pos.y;
          end
          if (pos.y >= hz_rd.high) begin
            hz_wdata.high = pos.y;
          end
          add_req = (hit != vis_q) && vis_q;
        end
        if (pos.done && !first_q) begin
          state_d = ST_W_END;
        end else begin
          step_en = 1'b1;
          state_d = ST_W_RD;
        end
      end
      ST_W_END: begin
        add_run = '{x_from: sx_q, y_from: sy_q, x_to: px_q, y_to: py_q};
        add_req = vis_q;
        state_d = ST_E_RD;
      end
      ST_E_RD: begin
        state_d = (emit_q == run_cnt_q) ? ST_IDLE : ST_E_LD;
      end
      ST_E_LD: begin
        state_d = ST_E_WAIT;
      end
      ST_E_WAIT: begin
        if (out_o.ready) begin
          state_d = ST_E_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rb_we = add_req && (run_cnt_q < RCW'(MAX_RUNS));

  // Control counters and flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      run_cnt_q <= '0;
      emit_q    <= '0;
      dropped_q <= 1'b0;
      first_q   <= 1'b0;
      vis_q     <= 1'b0;
    end else begin
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + CW'(1);
      end
      if (state_q == ST_IDLE && in_i.valid) begin
        clr_q     <= '0;
        run_cnt_q <= '0;
        emit_q    <= '0;
        dropped_q <= 1'b0;
      end
      if (add_req) begin
        if (rb_we) begin
          run_cnt_q <= run_cnt_q + RCW'(1);
        end else begin
          dropped_q <= 1'b1;
        end
      end
      if (state_q == ST_ORDER) begin
        first_q <= 1'b1;
      end
      if (state_q == ST_W_EV) begin
        first_q <= 1'b0;
        if (first_q || (hit != vis_q)) begin
          vis_q <= hit;
        end
      end
      if (state_q == ST_E_WAIT && out_o.ready) begin
        emit_q <= emit_q + RCW'(1);
      end
    end
  end

  // Payload registers of the current request and walker.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_i.valid) begin
      xa_q <= in_i.x_start;
      ya_q <= in_i.y_start;
      xb_q <= in_i.x_end;
      yb_q <= in_i.y_end;
    end
    if (state_q == ST_SETUP) begin
      dx_q <= dx_abs;
      dy_q <= dy_abs;
    end
    if (state_q == ST_ORDER) begin
      start_here_q <= (dy_q == '0);
      if (xa_q == xb_q && yb_q < ya_q) begin
        ya_q <= yb_q;
        yb_q <= ya_q;
      end
    end
    if (state_q == ST_VT_EV) begin
      r2_q <= vt_r2;
    end
    if (state_q == ST_W_EV) begin
      px_q <= pos.x;
      py_q <= pos.y;
      if (first_q) begin
        sx_q <= pos.x;
        sy_q <= pos.y;
      end else if (hit != vis_q) begin
        sx_q <= start_here_q ? pos.x : px_q;
        sy_q <= start_here_q ? pos.y : py_q;
      end
    end
    if (state_q == ST_E_LD) begin
      run_q  <= run_t'(rb_rdata);
      last_q <= (emit_q + RCW'(1)) == run_cnt_q;
      ovf_q  <= dropped_q;
    end
  end

  // Output channel.
  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = (state_q == ST_E_WAIT);
  assign out_o.seg_x_from = run_q.x_from;
  assign out_o.seg_y_from = run_q.y_from;
  assign out_o.seg_x_to   = run_q.x_to;
  assign out_o.seg_y_to   = run_q.y_to;
  assign out_o.last       = last_q;
  assign out_o.overflow   = ovf_q;

  // The run counter never passes the buffer depth.
  a_run_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_cnt_q <= RCW'(MAX_RUNS))
    else $error("run count exceeds buffer depth");

  // A run is dropped only when the buffer is full.
  a_drop_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dropped_q |-> (run_cnt_q == RCW'(MAX_RUNS)))
    else $error("run dropped with buffer space left");

  // No new request is taken while a result is pending.
  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid)
    else $error("request taken while a result is pending");

  // Each result is followed by a fresh buffer read before the next one.
  a_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready) |=> !out_o.valid)
    else $error("result shown twice");

endmodule

/* src/fhlc_ram.sv */
module fhlc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/fhlc_stepper.sv */
module fhlc_stepper (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  fhlc_pkg::step_init_t  init_i,
  input  logic                  step_i,
  output fhlc_pkg::step_pos_t   pos_o
);
  import fhlc_pkg::*;

  logic              steep_q, neg_q;
  col_t              x_q, x_end_q;
  hgt_t              y_q, y_end_q;
  logic [DW-1:0]     dmaj_q, dmin_q;
  logic [ERRW-1:0]   err_q;
  logic [ERRW-1:0]   err_sum;
  logic              minor_step;

  // Error term after one major step and whether the minor axis moves.
  always_comb begin
    err_sum    = err_q + ERRW'(dmin_q);
    minor_step = err_sum >= ERRW'(dmaj_q);
  end

  // Bresenham step: the major axis always advances by one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steep_q <= 1'b0;
      neg_q   <= 1'b0;
    end else if (load_i) begin
      steep_q <= init_i.steep;
      neg_q   <= init_i.neg;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q     <= init_i.x;
      y_q     <= init_i.y;
      x_end_q <= init_i.x_end;
      y_end_q <= init_i.y_end;
      dmaj_q  <= init_i.dmaj;
      dmin_q  <= init_i.dmin;
      err_q   <= ERRW'(init_i.dmaj >> 1);
    end else if (step_i) begin
      err_q <= minor_step ? (err_sum - ERRW'(dmaj_q)) : err_sum;
      if (steep_q) begin
        y_q <= y_q + hgt_t'(1);
        if (minor_step) begin
          x_q <= neg_q ? (x_q - col_t'(1)) : (x_q + col_t'(1));
        end
      end else begin
        x_q <= x_q + col_t'(1);
        if (minor_step) begin
          y_q <= neg_q ? (y_q - hgt_t'(1)) : (y_q + hgt_t'(1));
        end
      end
    end
  end

  assign pos_o.x    = x_q;
  assign pos_o.y    = y_q;
  assign pos_o.done = steep_q ? (y_q == y_end_q) : (x_q == x_end_q);

endmodule
